/* design/fbs_pkg.sv */
// Package for the frame byte stuffer: item types, descriptor type and framing codes.
`default_nettype none

package fbs_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'hF1;
    localparam logic [7:0] TAIL_BYTE = 8'hF2;
    localparam logic [7:0] ESC_BYTE  = 8'hF0;
    localparam logic [7:0] ESC_TAIL  = 8'h00;
    localparam logic [7:0] ESC_HEAD  = 8'h01;
    localparam logic [7:0] ESC_ESC   = 8'h02;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_first;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        out_item_t r0;
        out_item_t r1;
        logic      two;
    } desc_t;

    typedef struct packed {
        logic  empty;
        desc_t head;
    } queue_stat_t;

endpackage

`default_nettype wire

/* design/fbs_front.sv */
// Front end: classifies an input byte into a one- or two-result descriptor.
`default_nettype none

module fbs_front (
    input  wire fbs_pkg::in_item_t item,
    output fbs_pkg::desc_t         desc
);
    import fbs_pkg::*;

    always_comb
    begin
        desc.r0   = '{out_byte: item.data_byte, frame_end: 1'b0, run_last: 1'b1};
        desc.r1   = '{out_byte: TAIL_BYTE, frame_end: 1'b1, run_last: 1'b1};
        desc.two  = 1'b0;
        if (item.frame_first)
        begin
            desc.r0.out_byte = HEAD_BYTE;
            desc.r0.run_last = ~item.frame_last;
            desc.two         = item.frame_last;
        end
        else if (item.frame_last)
        begin
            desc.r0 = '{out_byte: TAIL_BYTE, frame_end: 1'b1, run_last: 1'b1};
        end
        else if (item.data_byte == HEAD_BYTE || item.data_byte == TAIL_BYTE ||
                 item.data_byte == ESC_BYTE)
        begin
            desc.r0.out_byte  = ESC_BYTE;
            desc.r0.run_last  = 1'b0;
            desc.r1.frame_end = 1'b0;
            desc.two          = 1'b1;
            case (item.data_byte)
                HEAD_BYTE: desc.r1.out_byte = ESC_HEAD;
                TAIL_BYTE: desc.r1.out_byte = ESC_TAIL;
                default:   desc.r1.out_byte = ESC_ESC;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/fbs_queue.sv */
// Descriptor queue between the front end and the serializer.
`default_nettype none

module fbs_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      wr_en,
    input  wire fbs_pkg::desc_t      wr_desc,
    input  wire                      rd_en,
    output logic                     full,
    output fbs_pkg::queue_stat_t     stat
);
    import fbs_pkg::*;

    desc_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.head  = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en & ~full;
    assign do_rd      = rd_en & ~stat.empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/fbs_back.sv */
// Back end: serializes descriptors into results through an output register.
`default_nettype none

module fbs_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire fbs_pkg::queue_stat_t  stat,
    output logic                       q_pop,
    output logic                       empty,
    input  wire                        pop,
    output fbs_pkg::out_item_t         result
);
    import fbs_pkg::*;

    out_item_t res_reg, res_next;
    logic      valid_reg, valid_next;
    logic      phase_reg, phase_next;
    logic      load;

    assign load   = ~valid_reg | pop;
    assign empty  = ~valid_reg;
    assign result = res_reg;

    always_comb
    begin
        res_next   = res_reg;
        valid_next = valid_reg & ~pop;
        phase_next = phase_reg;
        q_pop      = 1'b0;
        if (load && !stat.empty)
        begin
            valid_next = 1'b1;
            res_next   = phase_reg ? stat.head.r1 : stat.head.r0;
            if (stat.head.two && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

/* design/frame_byte_stuffer.sv */
// Top level of the frame byte stuffer: front end, descriptor queue, serializer.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | push / full      | item   : data_byte, frame_first, frame_last
//  result   | empty / pop      | result : out_byte, frame_end, run_last
//
// A request goes through the combinational classifier into a 4-entry queue;
// the serializer then loads its first result into the output register. It
// emits one result per cycle while pop takes them, so a plain byte yields one
// result and an escaped or head+tail byte two. Reset empties the queue and the
// output register. full rises only when the queue holds four descriptors; a
// result waiting on pop blocks push only once the queue has filled behind it.
`default_nettype none

module frame_byte_stuffer (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    output logic                     full,
    input  wire fbs_pkg::in_item_t   item,
    output logic                     empty,
    input  wire                      pop,
    output fbs_pkg::out_item_t       result
);
    import fbs_pkg::*;

    desc_t       desc;
    queue_stat_t stat;
    logic        q_pop;

    fbs_front u_front (
        .item (item),
        .desc (desc)
    );

    fbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_desc (desc),
        .rd_en   (q_pop),
        .full    (full),
        .stat    (stat)
    );

    fbs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat   (stat),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    a_tail_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |-> (result.out_byte == TAIL_BYTE && result.run_last))
        else $error("tail result malformed");

    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_byte == ESC_BYTE) |-> !result.run_last)
        else $error("escape byte marked as last of run");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.run_last) |=> !empty)
        else $error("second result of a pair not ready");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("queue drained without results being taken");

endmodule

`default_nettype wire
